[design/awd_pkg.sv]
// shared types and constants for the address window decoder
package awd_pkg;

	localparam int MAP_ENTRIES = 64;
	localparam int IDX_BITS    = 6;
	localparam int CFG_BITS    = 7;

	typedef enum logic {
		ACT_WRITE     = 1'b0,
		ACT_TRANSLATE = 1'b1
	} awd_act_t;

	// control part of the word that walks down the cell chain
	typedef struct packed {
		logic                valid;
		awd_act_t            action;
		logic [IDX_BITS-1:0] entry;
		logic                hit;
		logic [IDX_BITS-1:0] hit_entry;
	} awd_ctl_t;

endpackage

[design/awd_cell.sv]
// one map entry with its compare and its stage register of the chain
module awd_cell #(
	parameter int CELL_ID    = 0,
	parameter int ADDR_BITS  = 32,
	parameter int SLAVE_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [awd_pkg::CFG_BITS-1:0]  limit,
	input  awd_pkg::awd_ctl_t             in_ctl,
	input  logic [ADDR_BITS-1:0]          in_addr,
	input  logic [ADDR_BITS-1:0]          in_wbeg,
	input  logic [ADDR_BITS-1:0]          in_wend,
	input  logic [ADDR_BITS-1:0]          in_woff,
	input  logic [SLAVE_BITS-1:0]         in_wslv,
	input  logic [ADDR_BITS-1:0]          in_taddr,
	input  logic [SLAVE_BITS-1:0]         in_tslv,
	output awd_pkg::awd_ctl_t             out_ctl,
	output logic [ADDR_BITS-1:0]          out_addr,
	output logic [ADDR_BITS-1:0]          out_wbeg,
	output logic [ADDR_BITS-1:0]          out_wend,
	output logic [ADDR_BITS-1:0]          out_woff,
	output logic [SLAVE_BITS-1:0]         out_wslv,
	output logic [ADDR_BITS-1:0]          out_taddr,
	output logic [SLAVE_BITS-1:0]         out_tslv
);

	logic [ADDR_BITS-1:0]  begin_q;
	logic [ADDR_BITS-1:0]  end_q;
	logic [ADDR_BITS-1:0]  delta_q;
	logic [SLAVE_BITS-1:0] slave_q;

	awd_pkg::awd_ctl_t     ctl_s1;
	logic [ADDR_BITS-1:0]  addr_s1;
	logic [ADDR_BITS-1:0]  wbeg_s1;
	logic [ADDR_BITS-1:0]  wend_s1;
	logic [ADDR_BITS-1:0]  woff_s1;
	logic [SLAVE_BITS-1:0] wslv_s1;
	logic [ADDR_BITS-1:0]  taddr_s1;
	logic [SLAVE_BITS-1:0] tslv_s1;

	logic              load;
	logic              hit_here;
	awd_pkg::awd_ctl_t ctl_next;

	always_comb begin
		load = adv && in_ctl.valid && (in_ctl.action == awd_pkg::ACT_WRITE)
			&& (int'(in_ctl.entry) == CELL_ID);
		// only the first hit of the search order counts
		hit_here = in_ctl.valid && (in_ctl.action == awd_pkg::ACT_TRANSLATE) && !in_ctl.hit
			&& (CELL_ID < int'(limit)) && (in_addr >= begin_q) && (in_addr < end_q);
		ctl_next = in_ctl;
		if (hit_here) begin
			ctl_next.hit       = 1'b1;
			ctl_next.hit_entry = awd_pkg::IDX_BITS'(CELL_ID);
		end
	end

	// offset minus begin is folded at load time so a lookup needs one add
	always_ff @(posedge clk) begin
		if (load) begin
			begin_q <= in_wbeg;
			end_q   <= in_wend;
			delta_q <= in_woff - in_wbeg;
			slave_q <= in_wslv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1  <= in_addr;
			wbeg_s1  <= in_wbeg;
			wend_s1  <= in_wend;
			woff_s1  <= in_woff;
			wslv_s1  <= in_wslv;
			taddr_s1 <= hit_here ? in_addr + delta_q : in_taddr;
			tslv_s1  <= hit_here ? slave_q : in_tslv;
		end
	end

	assign out_ctl   = ctl_s1;
	assign out_addr  = addr_s1;
	assign out_wbeg  = wbeg_s1;
	assign out_wend  = wend_s1;
	assign out_woff  = woff_s1;
	assign out_wslv  = wslv_s1;
	assign out_taddr = taddr_s1;
	assign out_tslv  = tslv_s1;

endmodule

[design/address_window_decoder.sv]
// top level of the address window decoder: cell chain and output register
//
// usage: the input stream carries one word per bus request or table write.
// s_tuser is the action: write loads map entry entry_index with begin, end,
// offset and slave; translate looks up request_address. each translate word
// yields one result word on the master side; a write yields none.
// the map lives in a row of MAP_ENTRIES cells, one entry per cell. a word
// moves one cell per cycle and every cell checks it against its own entry,
// so the first cell that holds the address sets the result and later cells
// pass it on. writes and lookups travel the same row and stay in order.
// throughput: one word per cycle while the row is not held. a word goes
// through the MAP_ENTRIES cell registers and the output register to m_tdata.
// a miss gives no_match high with translated address, slave and entry zero.
// cfg_data sets how many entries from zero take part; write it while idle.
// reset clears the in-flight words and the register; map entries hold
// nothing defined until written. when m_tready is low with a result waiting,
// the whole row holds and s_tready drops until the result is taken.
module address_window_decoder #(
	parameter  int ADDR_BITS  = 32,
	parameter  int SLAVE_BITS = 8,
	localparam int S_DATA_W   = ((awd_pkg::IDX_BITS + 4 * ADDR_BITS + SLAVE_BITS + 7) / 8) * 8,
	localparam int M_DATA_W   = ((2 * ADDR_BITS + SLAVE_BITS + awd_pkg::IDX_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [awd_pkg::CFG_BITS-1:0]  cfg_data,   // entries_in_use
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// entry_index, window_begin, window_end, window_offset, window_slave,
	// request_address
	input  logic [S_DATA_W-1:0]           s_tdata,
	input  logic                          s_tuser,    // action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// translated_address, original_address, target_slave, matched_entry
	output logic [M_DATA_W-1:0]           m_tdata,
	output logic                          m_tuser     // no_match
);

	localparam int MAP_ENTRIES = awd_pkg::MAP_ENTRIES;
	localparam int IB          = awd_pkg::IDX_BITS;

	localparam int BEG_LO = IB;
	localparam int END_LO = BEG_LO + ADDR_BITS;
	localparam int OFF_LO = END_LO + ADDR_BITS;
	localparam int SLV_LO = OFF_LO + ADDR_BITS;
	localparam int REQ_LO = SLV_LO + SLAVE_BITS;

	logic [awd_pkg::CFG_BITS-1:0] limit_q;

	awd_pkg::awd_ctl_t     ctl_w   [MAP_ENTRIES+1];
	logic [ADDR_BITS-1:0]  addr_w  [MAP_ENTRIES+1];
	logic [ADDR_BITS-1:0]  wbeg_w  [MAP_ENTRIES+1];
	logic [ADDR_BITS-1:0]  wend_w  [MAP_ENTRIES+1];
	logic [ADDR_BITS-1:0]  woff_w  [MAP_ENTRIES+1];
	logic [SLAVE_BITS-1:0] wslv_w  [MAP_ENTRIES+1];
	logic [ADDR_BITS-1:0]  taddr_w [MAP_ENTRIES+1];
	logic [SLAVE_BITS-1:0] tslv_w  [MAP_ENTRIES+1];

	logic                  adv;
	logic                  out_valid_q;
	logic [ADDR_BITS-1:0]  out_taddr_q;
	logic [ADDR_BITS-1:0]  out_addr_q;
	logic [SLAVE_BITS-1:0] out_slave_q;
	logic [IB-1:0]         out_entry_q;
	logic                  out_miss_q;

	// the row moves only when the output register is free or being drained
	assign adv       = !out_valid_q || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	always_comb begin
		ctl_w[0]           = '0;
		ctl_w[0].valid     = s_tvalid;
		ctl_w[0].action    = awd_pkg::awd_act_t'(s_tuser);
		ctl_w[0].entry     = s_tdata[IB-1:0];
		ctl_w[0].hit       = 1'b0;
		ctl_w[0].hit_entry = '0;
		addr_w[0]  = s_tdata[REQ_LO +: ADDR_BITS];
		wbeg_w[0]  = s_tdata[BEG_LO +: ADDR_BITS];
		wend_w[0]  = s_tdata[END_LO +: ADDR_BITS];
		woff_w[0]  = s_tdata[OFF_LO +: ADDR_BITS];
		wslv_w[0]  = s_tdata[SLV_LO +: SLAVE_BITS];
		taddr_w[0] = '0;
		tslv_w[0]  = '0;
	end

	for (genvar k = 0; k < MAP_ENTRIES; k++) begin : g_cell
		awd_cell #(
			.CELL_ID   (k),
			.ADDR_BITS (ADDR_BITS),
			.SLAVE_BITS(SLAVE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.limit    (limit_q),
			.in_ctl   (ctl_w[k]),
			.in_addr  (addr_w[k]),
			.in_wbeg  (wbeg_w[k]),
			.in_wend  (wend_w[k]),
			.in_woff  (woff_w[k]),
			.in_wslv  (wslv_w[k]),
			.in_taddr (taddr_w[k]),
			.in_tslv  (tslv_w[k]),
			.out_ctl  (ctl_w[k+1]),
			.out_addr (addr_w[k+1]),
			.out_wbeg (wbeg_w[k+1]),
			.out_wend (wend_w[k+1]),
			.out_woff (woff_w[k+1]),
			.out_wslv (wslv_w[k+1]),
			.out_taddr(taddr_w[k+1]),
			.out_tslv (tslv_w[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_w[MAP_ENTRIES].valid
				&& (ctl_w[MAP_ENTRIES].action == awd_pkg::ACT_TRANSLATE);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_taddr_q <= taddr_w[MAP_ENTRIES];
			out_addr_q  <= addr_w[MAP_ENTRIES];
			out_slave_q <= tslv_w[MAP_ENTRIES];
			out_entry_q <= ctl_w[MAP_ENTRIES].hit_entry;
			out_miss_q  <= !ctl_w[MAP_ENTRIES].hit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_miss_q;
	assign m_tdata  = M_DATA_W'({out_entry_q, out_slave_q, out_addr_q, out_taddr_q});

endmodule

[design/awd_checker.sv]
// port-level checks for the address window decoder and their bind
module awd_checker #(
	parameter int ADDR_BITS  = 32,
	parameter int SLAVE_BITS = 8,
	parameter int M_DATA_W   = 80
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tuser
);

	localparam int RES_LO = 2 * ADDR_BITS;
	localparam int RES_W  = SLAVE_BITS + awd_pkg::IDX_BITS;

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result word shown during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result word changed");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while result word stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			(m_tdata[ADDR_BITS-1:0] == '0) && (m_tdata[RES_LO +: RES_W] == '0))
		else $error("miss word carries nonzero translation fields");

endmodule

bind address_window_decoder awd_checker #(
	.ADDR_BITS (ADDR_BITS),
	.SLAVE_BITS(SLAVE_BITS),
	.M_DATA_W  (M_DATA_W)
) u_awd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

[test/tb.sv]
// self-checking testbench for the address window decoder
`timescale 1ns / 100ps

module tb;

	localparam int MAP_ENTRIES  = awd_pkg::MAP_ENTRIES;
	localparam int S_WORD_BITS  = 144;
	localparam int M_WORD_BITS  = 80;
	localparam int DRAIN_CYCLES = MAP_ENTRIES + 16;

	// input word, lowest field last
	typedef struct packed {
		logic [1:0]  pad;
		logic [31:0] req_addr;
		logic [7:0]  slave;
		logic [31:0] offset;
		logic [31:0] wend;
		logic [31:0] wbegin;
		logic [5:0]  index;
	} req_word_t;

	// result word, lowest field last
	typedef struct packed {
		logic [1:0]  pad;
		logic [5:0]  entry;
		logic [7:0]  slave;
		logic [31:0] orig_addr;
		logic [31:0] xlat_addr;
	} rsp_word_t;

	typedef struct {
		rsp_word_t word;
		logic      miss;
	} lookup_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [awd_pkg::CFG_BITS-1:0] cfg_data;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [S_WORD_BITS-1:0]       s_tdata;
	logic                         s_tuser;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [M_WORD_BITS-1:0]       m_tdata;
	logic                         m_tuser;

	// predictor state
	logic [31:0]                  map_begin  [MAP_ENTRIES];
	logic [31:0]                  map_end    [MAP_ENTRIES];
	logic [31:0]                  map_offset [MAP_ENTRIES];
	logic [7:0]                   map_slave  [MAP_ENTRIES];
	logic [awd_pkg::CFG_BITS-1:0] search_count;

	lookup_t pending_lookups[$];
	int      error_count;
	int      send_idle_pct;
	int      recv_stall_pct;
	int      hold_cycles;

	address_window_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

	function automatic lookup_t translate_addr(logic [31:0] addr);
		lookup_t res;
		int      lim;
		res.word           = '0;
		res.word.orig_addr = addr;
		res.miss           = 1'b1;
		lim = (search_count > MAP_ENTRIES) ? MAP_ENTRIES : search_count;
		for (int i = 0; i < lim; i++) begin
			if (res.miss && addr >= map_begin[i] && addr < map_end[i]) begin
				res.word.xlat_addr = addr - map_begin[i] + map_offset[i];
				res.word.slave     = map_slave[i];
				res.word.entry     = i[5:0];
				res.miss           = 1'b0;
			end
		end
		return res;
	endfunction

	function automatic req_word_t make_word(logic [5:0] idx, logic [31:0] wb, logic [31:0] we,
			logic [31:0] wo, logic [7:0] sl, logic [31:0] ra);
		req_word_t w;
		w.pad      = '0;
		w.index    = idx;
		w.wbegin   = wb;
		w.wend     = we;
		w.offset   = wo;
		w.slave    = sl;
		w.req_addr = ra;
		return w;
	endfunction

	function automatic void log_error(string msg);
		error_count++;
		if (error_count <= 10)
			$display("tb: mismatch at %0t: %s", $realtime, msg);
	endfunction

	// one word on the input stream; entered and left just after a falling edge
	task automatic send_word(awd_pkg::awd_act_t act, req_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		if (act == awd_pkg::ACT_WRITE) begin
			map_begin[w.index]  = w.wbegin;
			map_end[w.index]    = w.wend;
			map_offset[w.index] = w.offset;
			map_slave[w.index]  = w.slave;
		end else begin
			pending_lookups.push_back(translate_addr(w.req_addr));
		end
		@(negedge clk);
	endtask

	task automatic send_lookup(logic [31:0] addr);
		send_word(awd_pkg::ACT_TRANSLATE, make_word(6'($urandom), $urandom, $urandom, $urandom,
			8'($urandom), addr));
	endtask

	task automatic send_entry(int idx, logic [31:0] wb, logic [31:0] we, logic [31:0] wo,
			logic [7:0] sl);
		send_word(awd_pkg::ACT_WRITE, make_word(idx[5:0], wb, we, wo, sl, $urandom));
	endtask

	// random window: mostly proper ranges, some empty or inverted
	task automatic send_random_entry(int idx);
		logic [31:0] wb;
		logic [31:0] we;
		int          pick;
		wb   = $urandom;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1, 2: begin
				wb = (wb > 32'hFFFF_FF00) ? 32'hFFFF_FF00 : wb;
				we = wb + $urandom_range(1, 256);
			end
			3, 4: begin
				wb = $urandom_range(0, 32'h7FFF_FFFF);
				we = wb + $urandom_range(1, 32'h7FFF_FFFF);
			end
			5: we = wb;
			6: we = (wb == 0) ? 32'h0 : $urandom_range(0, wb - 1);
			default: we = $urandom;
		endcase
		send_entry(idx, wb, we, $urandom, 8'($urandom));
	endtask

	// address near or inside a window that is searched, or at times a random one
	function automatic logic [31:0] aim_address(int lim);
		int          k;
		logic [31:0] size;
		k    = $urandom_range(0, lim - 1);
		size = map_end[k] - map_begin[k];
		case ($urandom_range(0, 5))
			0: return map_begin[k];
			1: return map_end[k] - 1;
			2: return map_end[k];
			3: return map_begin[k] - 1;
			4: return (map_begin[k] < map_end[k]) ?
				map_begin[k] + ($urandom % size) : map_begin[k];
			default: return $urandom;
		endcase
	endfunction

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(negedge clk);
		// writes leave nothing to wait for, so let the cell row empty out
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_search_count(logic [awd_pkg::CFG_BITS-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		search_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_pace(int idle_pct, int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	// receiver side: random stall, or a counted hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles--;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	rsp_word_t got_word;
	lookup_t   exp_lookup;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_word = m_tdata;
			if (pending_lookups.size() == 0) begin
				log_error($sformatf("result with nothing expected: %h user %b",
					m_tdata, m_tuser));
			end else begin
				exp_lookup = pending_lookups.pop_front();
				if (got_word.xlat_addr !== exp_lookup.word.xlat_addr ||
						got_word.orig_addr !== exp_lookup.word.orig_addr ||
						got_word.slave !== exp_lookup.word.slave ||
						got_word.entry !== exp_lookup.word.entry ||
						got_word.pad !== 2'b00 ||
						m_tuser !== exp_lookup.miss) begin
					log_error($sformatf(
						"addr %h: expected xlat %h slave %h entry %0d miss %b, got xlat %h slave %h entry %0d miss %b orig %h pad %b",
						exp_lookup.word.orig_addr, exp_lookup.word.xlat_addr,
						exp_lookup.word.slave, exp_lookup.word.entry, exp_lookup.miss,
						got_word.xlat_addr, got_word.slave, got_word.entry, m_tuser,
						got_word.orig_addr, got_word.pad));
				end
			end
		end
	end

	// nothing searched after reset, every lookup misses
	task automatic test_empty_map();
		set_pace(0, 0);
		send_lookup(32'h0000_0000);
		send_lookup(32'hFFFF_FFFF);
		send_lookup($urandom);
	endtask

	// hand-placed windows: edges, overlap priority, wrap, empty and inverted
	task automatic test_priority_windows();
		send_entry(0, 32'h0000_1000, 32'h0000_2000, 32'h0000_0000, 8'h01);
		send_entry(1, 32'h0000_1800, 32'h0000_3000, 32'hFFFF_F000, 8'hFF);
		send_entry(2, 32'h0000_0000, 32'h0000_0010, 32'h8000_0000, 8'h80);
		send_entry(3, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h7F);
		send_entry(4, 32'h0000_5000, 32'h0000_5000, 32'h1234_5678, 8'h55);
		send_entry(5, 32'h0000_7000, 32'h0000_6000, 32'h0000_0100, 8'h66);
		send_entry(6, 32'h4000_0000, 32'h4000_0001, 32'hDEAD_BEEF, 8'h00);
		send_entry(7, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 8'hAA);
		set_search_count(awd_pkg::CFG_BITS'(8));
		send_lookup(32'h0000_1000);
		send_lookup(32'h0000_1FFF);
		send_lookup(32'h0000_1800);
		send_lookup(32'h0000_2000);
		send_lookup(32'h0000_2FFF);
		send_lookup(32'h0000_0000);
		send_lookup(32'hFFFF_FF80);
		send_lookup(32'h0000_5000);
		send_lookup(32'h0000_6800);
		send_lookup(32'h4000_0000);
		send_lookup(32'hFFFF_FFFF);
		set_search_count(awd_pkg::CFG_BITS'(3));
		send_lookup(32'h0000_5000);
		send_lookup(32'h0000_1000);
	endtask

	// every entry gets written before the full table is searched
	task automatic test_fill_map();
		set_pace(0, 0);
		for (int i = 0; i < MAP_ENTRIES; i++)
			send_random_entry(i);
	endtask

	task automatic run_traffic(int count);
		int lim;
		int pick;
		for (int n = 0; n < count; n++) begin
			lim  = (search_count > MAP_ENTRIES) ? MAP_ENTRIES : search_count;
			pick = $urandom_range(0, 99);
			if (pick < 25)
				send_random_entry($urandom_range(0, MAP_ENTRIES - 1));
			else if (pick < 85 && lim > 0)
				send_lookup(aim_address(lim));
			else
				send_lookup($urandom);
		end
	endtask

	task automatic test_idle_phases();
		set_search_count(awd_pkg::CFG_BITS'(MAP_ENTRIES));
		set_pace(0, 0);
		run_traffic(220);
		set_search_count(awd_pkg::CFG_BITS'(1));
		set_pace(80, 0);
		run_traffic(220);
		set_search_count(awd_pkg::CFG_BITS'($urandom_range(2, MAP_ENTRIES - 1)));
		set_pace(0, 80);
		run_traffic(220);
		set_search_count(awd_pkg::CFG_BITS'(MAP_ENTRIES));
		set_pace(23, 23);
		run_traffic(220);
	endtask

	// receiver holds off long enough for the row to fill and stall the input
	task automatic test_backpressure();
		set_search_count(awd_pkg::CFG_BITS'(16));
		set_pace(0, 0);
		hold_cycles = 400;
		run_traffic(150);
	endtask

	// a count above the table size searches the whole table
	task automatic test_saturated_count();
		set_search_count(7'h7F);
		set_pace(23, 23);
		run_traffic(100);
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = awd_pkg::ACT_WRITE;
		m_tready       = 1'b0;
		error_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 0;
		search_count   = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_map();
		test_priority_windows();
		test_fill_map();
		test_idle_phases();
		test_backpressure();
		test_saturated_count();

		wait_idle();
		if (pending_lookups.size() != 0)
			log_error("results still expected at the end");
		if (error_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
